[rtl/timed_event_playback_sequencer_macros.svh]
// Assertion macros for the event playback sequencer.
`ifndef TIMED_EVENT_PLAYBACK_SEQUENCER_MACROS_SVH
`define TIMED_EVENT_PLAYBACK_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define TEPS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEPS_ASSERT(label, prop, msg) \
    `TEPS_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)
`else
`define TEPS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define TEPS_ASSERT(label, prop, msg)
`endif

`endif

[rtl/teps_pkg.sv]
package teps_pkg;

    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int LDELAY_W = 16;
    localparam int ACT_W    = 5;
    localparam int COUNT_W  = 7;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REWIND = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SLOT_W-1:0]   load_slot;
        logic [LDELAY_W-1:0] load_delay;
        logic [ACT_W-1:0]    load_action;
    } t_in;

    typedef struct packed {
        logic [ACT_W-1:0] action_number;
        logic             press;
        logic             complete;
        logic             last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } t_state;

endpackage

[rtl/timed_event_playback_sequencer.sv]
// Load and rewind words are handled in idle. A tick with no event left only advances the
// elapsed count; else the tick steps through the events it fires, each step being one read of
// the event store (synchronous read) and its compare; a stalled output holds the step. A
// fired event reaches the output register at the end of the next step, the one that checks
// the following event. Reset (synchronous, active low) clears position, elapsed count, held
// bits, event count and handshake state; the event store keeps whatever it holds.
`include "timed_event_playback_sequencer_macros.svh"

module timed_event_playback_sequencer #(
    parameter int MAX_EVENTS  = 64,
    parameter int NUM_ACTIONS = 32,
    parameter int DELAY_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  teps_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output teps_pkg::t_out                  o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [teps_pkg::COUNT_W-1:0]    i_cfg_data
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int HW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam int EW = DELAY_BITS + teps_pkg::ACT_W;

    // event store
    logic [EW-1:0] mem [MAX_EVENTS];
    logic [EW-1:0] r_rd_data;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    teps_pkg::t_state r_state, n_state;
    logic [CW-1:0]                 r_next, n_next;
    logic [31:0]                   r_elapsed, n_elapsed;
    logic [teps_pkg::COUNT_W-1:0]  r_count_cfg;
    logic [NUM_ACTIONS-1:0]        r_held, n_held;
    logic                          r_pend_v, n_pend_v;
    teps_pkg::t_out                r_pend, n_pend;
    logic                          r_ov;
    teps_pkg::t_out                r_out;

    logic                          out_free, out_load;
    teps_pkg::t_out                out_word;
    logic [CW-1:0]                 count, nxt1;
    logic [DELAY_BITS-1:0]         rd_delay;
    logic [teps_pkg::ACT_W-1:0]    rd_action;
    logic [8:0]                    act9;
    logic [HW-1:0]                 act_idx;
    logic                          act_ok, fire, press, complete;
    logic [31:0]                   elapsed_inc, ld_delay32;

    assign count = (r_count_cfg > teps_pkg::COUNT_W'(MAX_EVENTS)) ? CW'(MAX_EVENTS)
                                                                : CW'(r_count_cfg);
    assign {rd_delay, rd_action} = r_rd_data;
    assign act9        = {4'd0, rd_action};
    assign act_idx     = act9[HW-1:0];
    assign act_ok      = act9 < 9'(NUM_ACTIONS);
    assign press       = act_ok ? ~r_held[act_idx] : 1'b1;
    assign fire        = r_elapsed >= 32'(rd_delay);
    assign nxt1        = r_next + CW'(1);
    assign complete    = nxt1 >= count;
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
    assign out_free    = ~r_ov | ~i_out_stall;
    assign ld_delay32  = {16'd0, i_in.load_delay};
    assign waddr       = i_in.load_slot[AW-1:0];
    assign wdata       = {ld_delay32[DELAY_BITS-1:0], i_in.load_action};

    assign o_in_stall  = (r_state != teps_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= teps_pkg::ST_IDLE;
            r_next      <= '0;
            r_elapsed   <= '0;
            r_count_cfg <= '0;
            r_held      <= '0;
            r_pend_v    <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next    <= n_next;
            r_elapsed <= n_elapsed;
            r_held    <= n_held;
            r_pend_v  <= n_pend_v;
            if (i_cfg_valid) begin
                r_count_cfg <= i_cfg_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= out_word;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_elapsed = r_elapsed;
        n_held    = r_held;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        we        = 1'b0;
        re        = 1'b0;
        raddr     = r_next[AW-1:0];
        out_load  = 1'b0;
        out_word  = r_pend;
        case (r_state)
            teps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.mode)
                        teps_pkg::MODE_LOAD: begin
                            we = {1'b0, i_in.load_slot} < 7'(MAX_EVENTS);
                        end
                        teps_pkg::MODE_TICK: begin
                            if (r_next < count) begin
                                re      = 1'b1;
                                n_state = teps_pkg::ST_EVAL;
                            end else begin
                                n_elapsed = elapsed_inc;
                            end
                        end
                        teps_pkg::MODE_REWIND: begin
                            n_next    = '0;
                            n_elapsed = '0;
                            n_held    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            teps_pkg::ST_EVAL: begin
                if (fire) begin
                    // the previous event is known not to be last once this one fires
                    if (!r_pend_v || out_free) begin
                        out_load             = r_pend_v;
                        out_word.last        = 1'b0;
                        n_pend.action_number = rd_action;
                        n_pend.press         = press;
                        n_pend.complete      = complete;
                        n_pend.last          = 1'b0;
                        n_pend_v             = 1'b1;
                        n_next               = nxt1;
                        if (act_ok) begin
                            n_held[act_idx] = press;
                        end
                        if (complete) begin
                            n_elapsed = 32'd1;
                            n_state   = teps_pkg::ST_FLUSH;
                        end else begin
                            n_elapsed = '0;
                            re        = 1'b1;
                            raddr     = nxt1[AW-1:0];
                        end
                    end
                end else if (r_pend_v) begin
                    if (out_free) begin
                        out_load      = 1'b1;
                        out_word.last = 1'b1;
                        n_pend_v      = 1'b0;
                        n_elapsed     = elapsed_inc;
                        n_state       = teps_pkg::ST_IDLE;
                    end
                end else begin
                    n_elapsed = elapsed_inc;
                    n_state   = teps_pkg::ST_IDLE;
                end
            end
            teps_pkg::ST_FLUSH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_word.last = 1'b1;
                    n_pend_v      = 1'b0;
                    n_state       = teps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = teps_pkg::ST_IDLE;
            end
        endcase
    end

    `TEPS_ASSERT(a_pend_not_idle, r_pend_v |-> (r_state != teps_pkg::ST_IDLE), "pending word while idle")
    `TEPS_ASSERT(a_next_bound, r_next <= CW'(MAX_EVENTS), "position beyond store")
    `TEPS_ASSERT(a_complete_last, (o_out_valid && o_out.complete) |-> o_out.last, "complete without last")
    `TEPS_ASSERT(a_flush_pend, (r_state == teps_pkg::ST_FLUSH) |-> r_pend_v, "flush with no word")

endmodule
